// File: sv/wrsi_pkg.sv
// ----------------------------------------------------------------------------
// wrsi_pkg: shared types and constants of the Wilder RSI block
// Widths, fixed-point constants, the command and result structs passed
// between the top level and the arithmetic core, and the period clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package wrsi_pkg;

  // Field widths
  localparam int PRICE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int CFG_BITS   = 9;
  localparam int RSI_BITS   = 23;
  localparam int AVG_BITS   = 56;
  localparam int ACC_BITS   = 64;

  // Period limits
  localparam int MAX_PERIOD   = 256;
  localparam int PER_BITS     = $clog2(MAX_PERIOD) + 1;
  localparam int MR_BITS      = $clog2(MAX_PERIOD);
  localparam int REM_BITS     = $clog2(MAX_PERIOD);
  localparam int PERIOD_RESET = 14;

  // 100.0 in fixed point and its top set bit
  localparam int                HUNDRED_INT = 100 << FRAC_BITS;
  localparam logic [RSI_BITS-1:0] HUNDRED_FX = RSI_BITS'(HUNDRED_INT);
  localparam int                RATIO_TOP   = $clog2(HUNDRED_INT + 1) - 1;

  // Command from the front end to the core
  typedef struct packed {
    logic                  restart;
    logic [PRICE_BITS-1:0] gain;
    logic [PRICE_BITS-1:0] loss;
    logic [PER_BITS-1:0]   period;
  } wrsi_cmd_t;

  // Result from the core
  typedef struct packed {
    logic [RSI_BITS-1:0] rsi_value;
    logic                loss_flat;
  } wrsi_res_t;

  // Clamp the programmed period into 1..MAX_PERIOD
  function automatic logic [PER_BITS-1:0] period_in_use(input logic [CFG_BITS-1:0] v);
    logic [PER_BITS-1:0] p;
    if (v == '0) begin
      p = PER_BITS'(1);
    end else if (32'(v) > MAX_PERIOD) begin
      p = PER_BITS'(MAX_PERIOD);
    end else begin
      p = PER_BITS'(v);
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// File: sv/wrsi_ifs.sv
// ----------------------------------------------------------------------------
// wrsi_ifs: valid/ready channel interfaces of the Wilder RSI block
// Price input, period configuration and RSI result channels.
// ----------------------------------------------------------------------------
`default_nettype none

// Price samples
interface wrsi_in_if;
  logic                            valid;
  logic                            ready;
  logic [wrsi_pkg::PRICE_BITS-1:0] price;
  logic                            series_start;

  modport source (output valid, output price, output series_start, input ready);
  modport sink   (input valid, input price, input series_start, output ready);
endinterface

// Smoothing period writes
interface wrsi_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wrsi_pkg::CFG_BITS-1:0] smoothing_period;

  modport source (output valid, output smoothing_period, input ready);
  modport sink   (input valid, input smoothing_period, output ready);
endinterface

// RSI results
interface wrsi_out_if;
  logic                          valid;
  logic                          ready;
  logic [wrsi_pkg::RSI_BITS-1:0] rsi_value;
  logic                          loss_flat;

  modport source (output valid, output rsi_value, output loss_flat, input ready);
  modport sink   (input valid, input rsi_value, input loss_flat, output ready);
endinterface

`default_nettype wire

// File: sv/wilder_rsi.sv
// ----------------------------------------------------------------------------
// wilder_rsi: streaming relative strength index with Wilder smoothing
// Splits each price change into gain and loss, hands it to the arithmetic
// core and registers the RSI result toward the output channel.
// ----------------------------------------------------------------------------
// Sequence: a series start or first price clears the count and averages;
//   a change inside the summing window adds its gain and loss to the sums; a
//   change that yields an RSI goes through two period divisions, two multiplies
//   and, unless the loss average is zero, the RSI long division.
// Throughput: one transaction at a time; the next is taken when the core is idle.
// Reset: period returns to 14 and the price history is dropped.
`default_nettype none

module wilder_rsi (
  input logic         clk_i,
  input logic         rst_ni,
  wrsi_in_if.sink     in_i,
  wrsi_cfg_if.sink    cfg_i,
  wrsi_out_if.source  out_o
);
  import wrsi_pkg::*;

  // Period register
  logic [CFG_BITS-1:0] period_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= CFG_BITS'(PERIOD_RESET);
    end else if (cfg_i.valid) begin
      period_q <= cfg_i.smoothing_period;
    end
  end

  // Price history
  logic [PRICE_BITS-1:0] last_price_q;
  logic                  have_price_q;
  logic                  in_fire;
  logic                  cmd_ready;
  wrsi_cmd_t             cmd;
  logic                  price_up, price_down;

  assign in_i.ready = cmd_ready;
  assign in_fire    = in_i.valid && cmd_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_price_q <= 1'b0;
    end else if (in_fire) begin
      have_price_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      last_price_q <= in_i.price;
    end
  end

  // Gain and loss of this change
  assign price_up    = (in_i.price > last_price_q);
  assign price_down  = (in_i.price < last_price_q);
  assign cmd.restart = in_i.series_start || !have_price_q;
  assign cmd.gain    = price_up ? (in_i.price - last_price_q) : '0;
  assign cmd.loss    = price_down ? (last_price_q - in_i.price) : '0;
  assign cmd.period  = period_in_use(period_q);

  // Arithmetic core
  logic      res_valid, res_ready;
  wrsi_res_t res;

  wrsi_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (in_i.valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register
  logic      out_valid_q;
  wrsi_res_t out_q;

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.rsi_value = out_q.rsi_value;
  assign out_o.loss_flat = out_q.loss_flat;

endmodule

`default_nettype wire

// File: sv/wrsi_core.sv
// ----------------------------------------------------------------------------
// wrsi_core: sequenced arithmetic of the Wilder RSI
// Keeps the change count and both averages. One shared 64-bit add/subtract
// unit does the shift-add multiply by (period-1) and the RSI long division;
// a radix-16 step unit divides the smoothed sums by the period.
// ----------------------------------------------------------------------------
`default_nettype none

module wrsi_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  wrsi_pkg::wrsi_cmd_t cmd_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output wrsi_pkg::wrsi_res_t res_o
);
  import wrsi_pkg::*;

  localparam int DIV_RADIX = 4;
  localparam int DIV_STEPS = ACC_BITS / DIV_RADIX;
  localparam int STEP_BITS = $clog2(DIV_STEPS);
  localparam int BI_BITS   = $clog2(RATIO_TOP + 1);
  localparam int DEN_BITS  = AVG_BITS + 1;
  localparam int RR_BITS   = AVG_BITS + 2;
  localparam int CNT_BITS  = PER_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_SUM, S_RA, S_RB1, S_RB2, S_OUT
  } state_e;

  state_e state_q, state_d;

  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [AVG_BITS-1:0]   gavg_q, gavg_d, lavg_q, lavg_d;
  logic [PRICE_BITS-1:0] loss_q, loss_d;
  logic [PER_BITS-1:0]   per_q, per_d;
  logic                  sum_q, sum_d, fin_q, fin_d, side_q, side_d;
  logic [ACC_BITS-1:0]   acc_q, acc_d, mc_q, mc_d, dv_q, dv_d;
  logic [MR_BITS-1:0]    mr_q, mr_d;
  logic [REM_BITS-1:0]   rem_q, rem_d;
  logic [STEP_BITS-1:0]  step_q, step_d;
  logic [DEN_BITS-1:0]   den_q, den_d;
  logic [RR_BITS-1:0]    rr_q, rr_d;
  logic [RSI_BITS-1:0]   qt_q, qt_d;
  logic [BI_BITS-1:0]    bi_q, bi_d;
  logic                  flat_q, flat_d;

  // Shared add/subtract unit
  logic [ACC_BITS-1:0] add_a, add_b;
  logic                add_sub;
  logic [ACC_BITS:0]   add_res;
  logic                add_ge;

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_q)
      S_MUL: begin
        add_a = acc_q;
        add_b = mr_q[0] ? mc_q : '0;
      end
      S_SUM: begin
        add_a = ACC_BITS'(gavg_q);
        add_b = ACC_BITS'(lavg_q);
      end
      S_RA: begin
        add_a   = ACC_BITS'({rr_q[RR_BITS-2:0], 1'b0});
        add_b   = ACC_BITS'(den_q);
        add_sub = 1'b1;
      end
      S_RB1: begin
        add_a = ACC_BITS'(rr_q);
        add_b = ACC_BITS'(gavg_q);
      end
      S_RB2: begin
        add_a   = ACC_BITS'(rr_q);
        add_b   = ACC_BITS'(den_q);
        add_sub = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign add_res = {1'b0, add_a} + {1'b0, add_b ^ {ACC_BITS{add_sub}}}
                 + (ACC_BITS+1)'(add_sub);
  assign add_ge  = add_res[ACC_BITS];

  // Radix-16 restoring divide step by the period
  logic [REM_BITS-1:0] div_rem;
  logic [ACC_BITS-1:0] div_dv;
  logic [PER_BITS-1:0] div_t;
  logic                div_ge;

  always_comb begin
    div_rem = rem_q;
    div_dv  = dv_q;
    div_t   = '0;
    div_ge  = 1'b0;
    for (int k = 0; k < DIV_RADIX; k++) begin
      div_t  = {div_rem, div_dv[ACC_BITS-1]};
      div_ge = (div_t >= per_q);
      if (div_ge) begin
        div_t = div_t - per_q;
      end
      div_rem = div_t[REM_BITS-1:0];
      div_dv  = {div_dv[ACC_BITS-2:0], div_ge};
    end
  end

  // Helpers for the sequencer
  logic                summing_w, mul_last;
  logic [CNT_BITS-1:0] cnt_inc;
  logic [MR_BITS-1:0]  mr_load_cmd, mr_load;
  logic [ACC_BITS-1:0] loss_acc;
  logic [AVG_BITS-1:0] mul_sum, quot;

  assign summing_w   = (cnt_q < cmd_i.period);
  assign cnt_inc     = cnt_q + CNT_BITS'(1);
  assign mr_load_cmd = summing_w ? MR_BITS'(1) : MR_BITS'(cmd_i.period - PER_BITS'(1));
  assign mr_load     = sum_q ? MR_BITS'(1) : MR_BITS'(per_q - PER_BITS'(1));
  assign loss_acc    = ACC_BITS'({loss_q, {FRAC_BITS{1'b0}}});
  assign mul_last    = (mr_q[MR_BITS-1:1] == '0);
  assign mul_sum     = add_res[AVG_BITS-1:0];
  assign quot        = div_dv[AVG_BITS-1:0];

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    gavg_d  = gavg_q;
    lavg_d  = lavg_q;
    loss_d  = loss_q;
    per_d   = per_q;
    sum_d   = sum_q;
    fin_d   = fin_q;
    side_d  = side_q;
    acc_d   = acc_q;
    mc_d    = mc_q;
    mr_d    = mr_q;
    dv_d    = dv_q;
    rem_d   = rem_q;
    step_d  = step_q;
    den_d   = den_q;
    rr_d    = rr_q;
    qt_d    = qt_q;
    bi_d    = bi_q;
    flat_d  = flat_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.restart) begin
            cnt_d  = '0;
            gavg_d = '0;
            lavg_d = '0;
          end else begin
            loss_d  = cmd_i.loss;
            per_d   = cmd_i.period;
            sum_d   = summing_w;
            fin_d   = !summing_w || (cnt_inc >= cmd_i.period);
            if (summing_w) begin
              cnt_d = cnt_inc;
            end
            side_d  = 1'b0;
            acc_d   = ACC_BITS'({cmd_i.gain, {FRAC_BITS{1'b0}}});
            mc_d    = ACC_BITS'(gavg_q);
            mr_d    = mr_load_cmd;
            state_d = S_MUL;
          end
        end
      end
      // avg*m + x, one multiplier bit per cycle
      S_MUL: begin
        acc_d = add_res[ACC_BITS-1:0];
        mc_d  = {mc_q[ACC_BITS-2:0], 1'b0};
        mr_d  = mr_q >> 1;
        if (mul_last) begin
          rem_d  = '0;
          step_d = '0;
          if (sum_q) begin
            if (side_q) begin
              lavg_d = mul_sum;
            end else begin
              gavg_d = mul_sum;
            end
            dv_d = ACC_BITS'(mul_sum);
            if (fin_q) begin
              state_d = S_DIV;
            end else if (!side_q) begin
              side_d  = 1'b1;
              acc_d   = loss_acc;
              mc_d    = ACC_BITS'(lavg_q);
              mr_d    = mr_load;
              state_d = S_MUL;
            end else begin
              state_d = S_IDLE;
            end
          end else begin
            dv_d    = add_res[ACC_BITS-1:0];
            state_d = S_DIV;
          end
        end
      end
      // Divide by the period, four quotient bits per cycle
      S_DIV: begin
        dv_d   = div_dv;
        rem_d  = div_rem;
        step_d = step_q + STEP_BITS'(1);
        if (step_q == STEP_BITS'(DIV_STEPS - 1)) begin
          if (!side_q) begin
            gavg_d  = quot;
            side_d  = 1'b1;
            acc_d   = loss_acc;
            mc_d    = ACC_BITS'(lavg_q);
            mr_d    = mr_load;
            state_d = S_MUL;
          end else begin
            lavg_d  = quot;
            state_d = S_SUM;
          end
        end
      end
      // Denominator g+l, or the flat-loss shortcut
      S_SUM: begin
        if (lavg_q == '0) begin
          qt_d    = HUNDRED_FX;
          flat_d  = 1'b1;
          state_d = S_OUT;
        end else begin
          den_d   = add_res[DEN_BITS-1:0];
          rr_d    = '0;
          qt_d    = '0;
          flat_d  = 1'b0;
          bi_d    = BI_BITS'(RATIO_TOP);
          state_d = S_RA;
        end
      end
      // Long division step: shift remainder, compare-subtract
      S_RA: begin
        rr_d = add_ge ? add_res[RR_BITS-1:0] : {rr_q[RR_BITS-2:0], 1'b0};
        qt_d = {qt_q[RSI_BITS-2:0], add_ge};
        if (HUNDRED_FX[bi_q]) begin
          state_d = S_RB1;
        end else if (bi_q == '0) begin
          state_d = S_OUT;
        end else begin
          bi_d = bi_q - BI_BITS'(1);
        end
      end
      // Multiplicand bit set: add the gain average
      S_RB1: begin
        rr_d    = add_res[RR_BITS-1:0];
        state_d = S_RB2;
      end
      S_RB2: begin
        if (add_ge) begin
          rr_d = add_res[RR_BITS-1:0];
          qt_d = qt_q + RSI_BITS'(1);
        end
        if (bi_q == '0) begin
          state_d = S_OUT;
        end else begin
          bi_d    = bi_q - BI_BITS'(1);
          state_d = S_RA;
        end
      end
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, datapath and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      side_q  <= 1'b0;
      sum_q   <= 1'b0;
      fin_q   <= 1'b0;
      step_q  <= '0;
      bi_q    <= '0;
      gavg_q  <= '0;
      lavg_q  <= '0;
      loss_q  <= '0;
      per_q   <= '0;
      acc_q   <= '0;
      mc_q    <= '0;
      mr_q    <= '0;
      dv_q    <= '0;
      rem_q   <= '0;
      den_q   <= '0;
      rr_q    <= '0;
      qt_q    <= '0;
      flat_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      side_q  <= side_d;
      sum_q   <= sum_d;
      fin_q   <= fin_d;
      step_q  <= step_d;
      bi_q    <= bi_d;
      gavg_q  <= gavg_d;
      lavg_q  <= lavg_d;
      loss_q  <= loss_d;
      per_q   <= per_d;
      acc_q   <= acc_d;
      mc_q    <= mc_d;
      mr_q    <= mr_d;
      dv_q    <= dv_d;
      rem_q   <= rem_d;
      den_q   <= den_d;
      rr_q    <= rr_d;
      qt_q    <= qt_d;
      flat_q  <= flat_d;
    end
  end

  assign cmd_ready_o     = (state_q == S_IDLE);
  assign res_valid_o     = (state_q == S_OUT);
  assign res_o.rsi_value = qt_q;
  assign res_o.loss_flat = flat_q;

  // Checks
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> PER_BITS'(rem_q) < per_q)
    else $error("divider remainder not below period");

  a_ratio_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RA |-> rr_q < RR_BITS'(den_q))
    else $error("RSI remainder not below denominator");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_BITS'(MAX_PERIOD))
    else $error("change count beyond maximum period");

  a_rsi_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |-> qt_q <= HUNDRED_FX)
    else $error("RSI above 100");

  a_flat_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && flat_q |-> lavg_q == '0)
    else $error("flat flag with nonzero loss average");

endmodule

`default_nettype wire

// File: verif/wilder_rsi_tb.sv
// ----------------------------------------------------------------------------
// wilder_rsi_tb: self-checking testbench of the Wilder RSI block
// Feeds price series through the input channel, predicts every RSI result
// from its own copy of the smoothing state and compares each result
// transaction field by field. Covers directed corner prices, period changes
// mid-series, a long receiver hold-off and random walks under random idling.
// ----------------------------------------------------------------------------
module wilder_rsi_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wrsi_pkg::*;

  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_LEN     = 2000;

  typedef struct {
    logic [PRICE_BITS-1:0] price;
    logic                  series_start;
  } price_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  wrsi_in_if  in_if ();
  wrsi_cfg_if cfg_if ();
  wrsi_out_if out_if ();

  wilder_rsi DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // Pending prices and expected RSI results
  price_item_t price_queue[$];
  wrsi_res_t   rsi_expected[$];

  // Predictor state
  logic [CFG_BITS-1:0]   period_reg   = CFG_BITS'(PERIOD_RESET);
  logic [PRICE_BITS-1:0] prev_price   = '0;
  logic                  price_held   = 1'b0;
  logic [CFG_BITS-1:0]   changes_seen = '0;
  logic [AVG_BITS-1:0]   gain_mean    = '0;
  logic [AVG_BITS-1:0]   loss_mean    = '0;

  // Stimulus controls, changed only at falling edges
  int unsigned           tx_idle_pct = 0;
  int unsigned           rx_idle_pct = 0;
  logic                  hold_on     = 1'b0;
  int unsigned           hold_cycles;
  logic                  rx_hold;
  logic [PRICE_BITS-1:0] walk_price  = '0;
  logic                  walk_up     = 1'b1;
  int                    errors      = 0;

  always #4 clk_i = ~clk_i;

  // Update the smoothing state with one accepted price, queue its RSI if any
  task automatic track_price(input logic [PRICE_BITS-1:0] price, input logic start);
    logic [63:0]  up;
    logic [63:0]  down;
    logic [63:0]  span;
    logic [127:0] ratio;
    wrsi_res_t    res;
    if (start || !price_held) begin
      prev_price   = price;
      price_held   = 1'b1;
      changes_seen = '0;
      gain_mean    = '0;
      loss_mean    = '0;
      return;
    end
    up         = (price > prev_price) ? 64'(price - prev_price) : 64'd0;
    down       = (price < prev_price) ? 64'(prev_price - price) : 64'd0;
    prev_price = price;
    // zero acts as one, anything over the maximum as the maximum
    if (period_reg == '0) begin
      span = 64'd1;
    end else if (period_reg > CFG_BITS'(MAX_PERIOD)) begin
      span = 64'(MAX_PERIOD);
    end else begin
      span = 64'(period_reg);
    end
    if (64'(changes_seen) < span) begin
      // still collecting the first sums
      gain_mean    = AVG_BITS'(64'(gain_mean) + (up << FRAC_BITS));
      loss_mean    = AVG_BITS'(64'(loss_mean) + (down << FRAC_BITS));
      changes_seen = changes_seen + 1'b1;
      if (64'(changes_seen) < span) return;
      gain_mean = AVG_BITS'(64'(gain_mean) / span);
      loss_mean = AVG_BITS'(64'(loss_mean) / span);
    end else begin
      gain_mean = AVG_BITS'((64'(gain_mean) * (span - 1) + (up << FRAC_BITS)) / span);
      loss_mean = AVG_BITS'((64'(loss_mean) * (span - 1) + (down << FRAC_BITS)) / span);
    end
    if (loss_mean == '0) begin
      res.rsi_value = HUNDRED_FX;
      res.loss_flat = 1'b1;
    end else begin
      ratio = (128'(gain_mean) * 128'(HUNDRED_INT)) / (128'(gain_mean) + 128'(loss_mean));
      res.rsi_value = ratio[RSI_BITS-1:0];
      res.loss_flat = 1'b0;
    end
    rsi_expected = {rsi_expected, res};
  endtask

  // Price driver: predicts on acceptance, offers the next pending price
  always @(posedge clk_i) begin : price_driver
    price_item_t nxt;
    logic        offer;
    if (in_if.valid && in_if.ready) begin
      track_price(in_if.price, in_if.series_start);
    end
    if (!in_if.valid || in_if.ready) begin
      offer = 1'b0;
      if (price_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt   = price_queue.pop_front();
        offer = 1'b1;
        in_if.price        <= nxt.price;
        in_if.series_start <= nxt.series_start;
      end
      in_if.valid <= offer;
    end
  end

  // Long receiver hold-off, counted once
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cycles <= 0;
    end else if (hold_on && hold_cycles < HOLD_LEN) begin
      hold_cycles <= hold_cycles + 1;
    end
  end
  assign rx_hold = hold_on && (hold_cycles < HOLD_LEN);

  // Result monitor: checks each transaction against the oldest expectation
  always @(posedge clk_i) begin : rsi_monitor
    wrsi_res_t want;
    if (out_if.valid && out_if.ready) begin
      if (rsi_expected.size() == 0) begin
        $error("unexpected result: rsi_value %0d loss_flat %0d",
               out_if.rsi_value, out_if.loss_flat);
        errors++;
      end else begin
        want = rsi_expected.pop_front();
        if (out_if.rsi_value !== want.rsi_value) begin
          $error("rsi_value: expected %0d, actual %0d", want.rsi_value, out_if.rsi_value);
          errors++;
        end
        if (out_if.loss_flat !== want.loss_flat) begin
          $error("loss_flat: expected %0d, actual %0d", want.loss_flat, out_if.loss_flat);
          errors++;
        end
      end
    end
    out_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic push_price(input logic [PRICE_BITS-1:0] price, input logic start);
    price_item_t item;
    item.price        = price;
    item.series_start = start;
    price_queue = {price_queue, item};
  endtask

  // Random walk with trending runs, flat steps, jumps and occasional restarts
  task automatic queue_walk(input int count, input int unsigned start_pct);
    int unsigned           pick;
    logic [PRICE_BITS-1:0] step;
    int                    i;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if ($urandom_range(99) < 12) walk_up = ~walk_up;
      if (pick < 8) begin
        walk_price = $urandom();
      end else begin
        if (pick < 18) begin
          step = '0;
        end else if (pick < 60) begin
          step = $urandom_range(64);
        end else if (pick < 85) begin
          step = $urandom_range(32'h000F_FFFF);
        end else begin
          step = $urandom() >> $urandom_range(31);
        end
        walk_price = walk_up ? walk_price + step : walk_price - step;
      end
      push_price(walk_price, $urandom_range(99) < start_pct);
    end
  endtask

  // Wait until every price is taken and every result has come back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (price_queue.size() != 0 || in_if.valid || rsi_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_period(input logic [CFG_BITS-1:0] value);
    @(posedge clk_i);
    cfg_if.valid            <= 1'b1;
    cfg_if.smoothing_period <= value;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    period_reg = value;
    @(negedge clk_i);
  endtask

  // Main sequence
  initial begin
    in_if.valid             = 1'b0;
    in_if.price             = '0;
    in_if.series_start      = 1'b0;
    cfg_if.valid            = 1'b0;
    cfg_if.smoothing_period = '0;
    out_if.ready            = 1'b0;
    rst_ni                  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);

    // period zero acts as one: extreme moves, flat change, restarts
    write_period('0);
    push_price(32'h0000_0000, 1'b0);  // first price without flag
    push_price(32'hFFFF_FFFF, 1'b0);  // largest gain
    push_price(32'h0000_0000, 1'b0);  // largest loss
    push_price(32'h0000_0000, 1'b0);  // no change at all
    push_price(32'h0000_1234, 1'b1);
    push_price(32'h0000_1233, 1'b0);
    push_price(32'h8000_0000, 1'b1);
    push_price(32'h7FFF_FFFF, 1'b0);
    push_price(32'h8000_0000, 1'b0);
    wait_idle();

    // period two: rises only, then a fall and a jump to the top
    write_period(CFG_BITS'(2));
    push_price(32'd100, 1'b1);
    push_price(32'd200, 1'b0);
    push_price(32'd300, 1'b0);
    push_price(32'd250, 1'b0);
    push_price(32'hFFFF_FFFF, 1'b0);
    wait_idle();

    // period lowered below the collected count while still summing
    write_period(CFG_BITS'(14));
    push_price(32'd5000, 1'b1);
    push_price(32'd5100, 1'b0);
    push_price(32'd4900, 1'b0);
    push_price(32'd5300, 1'b0);
    push_price(32'd5000, 1'b0);
    push_price(32'd5050, 1'b0);
    wait_idle();
    write_period(CFG_BITS'(3));
    push_price(32'd5200, 1'b0);
    push_price(32'd4800, 1'b0);
    push_price(32'd4800, 1'b0);
    wait_idle();

    // receiver holds off while prices keep coming, so the block backs up
    write_period(CFG_BITS'(1));
    hold_on = 1'b1;
    queue_walk(40, 0);
    wait_idle();

    // sender idles now and then, receiver idles often... then the reverse
    tx_idle_pct = 32;
    rx_idle_pct = 74;
    write_period(CFG_BITS'(5));
    queue_walk(100, 3);
    wait_idle();
    write_period(CFG_BITS'(1));
    queue_walk(100, 3);
    wait_idle();

    tx_idle_pct = 74;
    rx_idle_pct = 32;
    write_period(CFG_BITS'(14));
    queue_walk(120, 2);
    wait_idle();
    write_period(CFG_BITS'(3));
    queue_walk(80, 3);
    wait_idle();

    // no idling: the largest period, values above it, then just below it
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_period(CFG_BITS'(MAX_PERIOD));
    queue_walk(260, 0);
    wait_idle();
    write_period(CFG_BITS'(511));
    queue_walk(30, 0);
    wait_idle();
    write_period(CFG_BITS'(255));
    queue_walk(30, 0);
    wait_idle();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
sv/wrsi_pkg.sv
sv/wrsi_ifs.sv
sv/wrsi_core.sv
sv/wilder_rsi.sv
verif/wilder_rsi_tb.sv
